### rtl/sha1_message_digest_assert.svh
// Assertion helpers; expect signals named clock and reset in the using scope.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication.
`define SHA1_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SHA1_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sha1_pkg.sv
package sha1_pkg;

   localparam int unsigned DIGEST_WORDS = 5;
   localparam logic [2:0] LAST_WORD_NUM = 3'd4;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         insert;
      byte_sel_type byte_sel;
      logic         count_bits;
      logic         start_block;
      logic         round_en;
      logic [6:0]   round_num;
      logic         add_en;
      logic         rotate_out;
      logic         restart;
   } cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_len_field;
   } status_type;

endpackage

### rtl/sha1_chan_if.sv
interface sha1_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/sha1_ctrl.sv
`include "sha1_message_digest_assert.svh"

module sha1_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  byte_present,
   input  logic                  end_of_message,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            word_number,
   output logic                  last_word,
   output sha1_pkg::cmd_type     cmd,
   input  sha1_pkg::status_type  status
);

   sha1_pkg::state_type state_ff, state_in;
   sha1_pkg::state_type ret_ff, ret_in;
   logic [6:0]          round_ff, round_in;
   logic [2:0]          word_ff, word_in;

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (byte_present && status.pos_last) begin
                  state_in = sha1_pkg::ST_ROUND;
                  ret_in   = end_of_message ? sha1_pkg::ST_PAD_MARK : sha1_pkg::ST_IDLE;
               end else if (end_of_message) begin
                  state_in = sha1_pkg::ST_PAD_MARK;
               end
            end
         end
         sha1_pkg::ST_PAD_MARK: begin
            if (status.pos_last) begin
               state_in = sha1_pkg::ST_ROUND;
               ret_in   = sha1_pkg::ST_PAD_ZERO;
            end else begin
               state_in = sha1_pkg::ST_PAD_ZERO;
            end
         end
         sha1_pkg::ST_PAD_ZERO: begin
            if (status.pos_len_field) begin
               state_in = sha1_pkg::ST_PAD_LEN;
            end else if (status.pos_last) begin
               state_in = sha1_pkg::ST_ROUND;
               ret_in   = sha1_pkg::ST_PAD_ZERO;
            end
         end
         sha1_pkg::ST_PAD_LEN: begin
            // eighth length byte lands on the last slot of the block
            if (status.pos_last) begin
               state_in = sha1_pkg::ST_ROUND;
               ret_in   = sha1_pkg::ST_EMIT;
            end
         end
         sha1_pkg::ST_ROUND: begin
            if (round_ff == sha1_pkg::LAST_ROUND) begin
               state_in = sha1_pkg::ST_ADD;
            end
         end
         sha1_pkg::ST_ADD: begin
            state_in = ret_ff;
         end
         sha1_pkg::ST_EMIT: begin
            if (rsp_ready && word_ff == sha1_pkg::LAST_WORD_NUM) begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.byte_sel  = sha1_pkg::SEL_MSG;
      cmd.round_num = round_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         sha1_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.insert      = req_valid && byte_present;
            cmd.count_bits  = req_valid && byte_present;
            cmd.start_block = req_valid && byte_present && status.pos_last;
         end
         sha1_pkg::ST_PAD_MARK: begin
            cmd.insert      = 1'b1;
            cmd.byte_sel    = sha1_pkg::SEL_MARK;
            cmd.start_block = status.pos_last;
         end
         sha1_pkg::ST_PAD_ZERO: begin
            cmd.insert      = !status.pos_len_field;
            cmd.byte_sel    = sha1_pkg::SEL_ZERO;
            cmd.start_block = !status.pos_len_field && status.pos_last;
         end
         sha1_pkg::ST_PAD_LEN: begin
            cmd.insert      = 1'b1;
            cmd.byte_sel    = sha1_pkg::SEL_LEN;
            cmd.start_block = status.pos_last;
         end
         sha1_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         sha1_pkg::ST_ADD: begin
            cmd.add_en = 1'b1;
         end
         sha1_pkg::ST_EMIT: begin
            rsp_valid      = 1'b1;
            cmd.rotate_out = rsp_ready;
            cmd.restart    = rsp_ready && word_ff == sha1_pkg::LAST_WORD_NUM;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      round_in = (state_ff == sha1_pkg::ST_ROUND) ? round_ff + 7'd1 : 7'd0;
      word_in  = word_ff;
      if (state_ff == sha1_pkg::ST_EMIT && rsp_ready) begin
         word_in = (word_ff == sha1_pkg::LAST_WORD_NUM) ? 3'd0 : word_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1_pkg::ST_IDLE;
         ret_ff   <= sha1_pkg::ST_IDLE;
         round_ff <= 7'd0;
         word_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   assign word_number = word_ff;
   assign last_word   = (word_ff == sha1_pkg::LAST_WORD_NUM);

   `SHA1_ASSERT_IMP(a_no_overlap, rsp_valid, !req_ready, "input taken while digest pending")
   `SHA1_ASSERT_IMP(a_round_range, state_ff == sha1_pkg::ST_ROUND, round_ff <= sha1_pkg::LAST_ROUND, "round counter past last round")
   `SHA1_ASSERT_NXT(a_round_to_add, state_ff == sha1_pkg::ST_ROUND && round_ff == sha1_pkg::LAST_ROUND, state_ff == sha1_pkg::ST_ADD, "final round not followed by add")
   `SHA1_ASSERT_NXT(a_emit_done, rsp_valid && rsp_ready && last_word, state_ff == sha1_pkg::ST_IDLE && word_ff == 3'd0, "digest end did not return to idle")

endmodule

### rtl/sha1_datapath.sv
module sha1_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            message_byte,
   input  sha1_pkg::cmd_type     cmd,
   output sha1_pkg::status_type  status,
   output logic [31:0]           digest_word
);

   // 64-byte block window, byte 0 in the top bits; during rounds it holds W[t..t+15]
   logic [511:0] blk_ff, blk_in;
   logic [31:0]  h_ff [sha1_pkg::DIGEST_WORDS];
   logic [31:0]  h_in [sha1_pkg::DIGEST_WORDS];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [5:0]   pos_ff, pos_in;
   logic [63:0]  count_ff, count_in;

   logic [7:0]   ins_byte;
   logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
   logic [31:0]  f_val, k_val, t_val;

   always_comb begin
      case (cmd.byte_sel)
         sha1_pkg::SEL_MSG:  ins_byte = message_byte;
         sha1_pkg::SEL_MARK: ins_byte = sha1_pkg::PAD_BYTE;
         sha1_pkg::SEL_ZERO: ins_byte = 8'h00;
         sha1_pkg::SEL_LEN:  ins_byte = count_ff[63:56];
         default:            ins_byte = 8'h00;
      endcase
   end

   assign w0    = blk_ff[511:480];
   assign w2    = blk_ff[447:416];
   assign w8    = blk_ff[255:224];
   assign w13   = blk_ff[95:64];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {w_mix[30:0], w_mix[31]};

   always_comb begin
      if (cmd.round_num < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1_pkg::K_0;
      end else if (cmd.round_num < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1_pkg::K_1;
      end else if (cmd.round_num < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1_pkg::K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1_pkg::K_3;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w0;
   end

   always_comb begin
      blk_in = blk_ff;
      if (cmd.insert) begin
         blk_in = {blk_ff[503:0], ins_byte};
      end else if (cmd.round_en) begin
         blk_in = {blk_ff[479:0], w_new};
      end

      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.start_block) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end else if (cmd.round_en) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
         h_in[i] = h_ff[i];
      end
      pos_in   = pos_ff;
      count_in = count_ff;
      if (cmd.restart) begin
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            h_in[i] = sha1_pkg::H_INIT[i];
         end
         pos_in   = 6'd0;
         count_in = 64'd0;
      end else begin
         if (cmd.add_en) begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
         end else if (cmd.rotate_out) begin
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS - 1; i++) begin
               h_in[i] = h_ff[i + 1];
            end
            h_in[sha1_pkg::DIGEST_WORDS - 1] = h_ff[0];
         end
         if (cmd.insert) begin
            pos_in = pos_ff + 6'd1;
         end
         if (cmd.count_bits) begin
            count_in = count_ff + 64'd8;
         end else if (cmd.insert && cmd.byte_sel == sha1_pkg::SEL_LEN) begin
            // length goes out big-endian, top byte first
            count_in = {count_ff[55:0], 8'h00};
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            h_ff[i] <= sha1_pkg::H_INIT[i];
         end
         pos_ff   <= 6'd0;
         count_ff <= 64'd0;
      end else begin
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            h_ff[i] <= h_in[i];
         end
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   assign status.pos_last      = (pos_ff == 6'd63);
   assign status.pos_len_field = (pos_ff == sha1_pkg::LEN_FIELD_POS);
   assign digest_word          = h_ff[0];

endmodule

### rtl/sha1_message_digest.sv
// Byte items are taken while idle; a byte that completes a 64-byte block starts a
// compression (80 rounds on the single round unit plus the chaining add) and holds
// off input. End of message: padding loads one byte per cycle outside its one or two
// compressions, plus one pass at the length field, then one digest word per ready cycle.
// Reset (synchronous, active high): initial hash loaded, byte position and bit
// count cleared, idle; the block buffer is not cleared.
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   sha1_chan_if.sink   req_if,
   sha1_chan_if.source rsp_if
);

   sha1_pkg::cmd_type    cmd;
   sha1_pkg::status_type status;
   sha1_pkg::req_payload_type req_payload;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   assign req_payload = req_if.payload;

   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .byte_present   (req_payload.byte_present),
      .end_of_message (req_payload.end_of_message),
      .req_ready      (req_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .word_number    (word_number),
      .last_word      (last_word),
      .cmd            (cmd),
      .status         (status)
   );

   sha1_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .message_byte (req_payload.message_byte),
      .cmd          (cmd),
      .status       (status),
      .digest_word  (digest_word)
   );

   assign rsp_if.payload = '{digest_word: digest_word, word_number: word_number,
                             last_word: last_word};

endmodule

### tb/sv/sha1_digest_checker.sv
module sha1_digest_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  sha1_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sha1_pkg::rsp_payload_type rsp_payload,
   output int                        mismatch_count,
   output int                        words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] hash_state [sha1_pkg::DIGEST_WORDS];
   logic [31:0] block_words [16];
   logic [5:0]  fill_pos;
   logic [63:0] bit_length;
   sha1_pkg::rsp_payload_type expected_digest [$];

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
         hash_state[i] = sha1_pkg::H_INIT[i];
      end
      fill_pos = '0;
      bit_length = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) begin
         w[i] = block_words[i];
      end
      for (int i = 16; i < 80; i++) begin
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::K_0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = sha1_pkg::K_1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::K_2;
         end else begin
            f = b ^ c ^ d;
            k = sha1_pkg::K_3;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endtask

   // big-endian placement; the bytes after this one in its word are cleared
   task automatic place_byte(input logic [5:0] pos, input logic [7:0] v);
      logic [31:0] w;
      w = block_words[pos[5:2]];
      case (pos[1:0])
         2'd0: w = {v, 24'h0};
         2'd1: w = {w[31:24], v, 16'h0};
         2'd2: w = {w[31:16], v, 8'h0};
         default: w = {w[31:8], v};
      endcase
      block_words[pos[5:2]] = w;
   endtask

   task automatic absorb_item(input sha1_pkg::req_payload_type item);
      logic [5:0] p;
      sha1_pkg::rsp_payload_type word_item;
      if (item.byte_present) begin
         place_byte(fill_pos, item.message_byte);
         bit_length += 64'd8;
         fill_pos += 6'd1;
         if (fill_pos == 6'd0) begin
            compress_block();
         end
      end
      if (!item.end_of_message) begin
         return;
      end
      p = fill_pos;
      place_byte(p, sha1_pkg::PAD_BYTE);
      for (int i = int'(p[5:2]) + 1; i < 16; i++) begin
         block_words[i] = '0;
      end
      // no room left for the length: pad out this block, length goes in the next
      if (p >= sha1_pkg::LEN_FIELD_POS) begin
         compress_block();
         for (int i = 0; i < 16; i++) begin
            block_words[i] = '0;
         end
      end
      block_words[14] = bit_length[63:32];
      block_words[15] = bit_length[31:0];
      compress_block();
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
         word_item = '{digest_word: hash_state[i], word_number: 3'(i),
                       last_word: (3'(i) == sha1_pkg::LAST_WORD_NUM)};
         expected_digest = {expected_digest, word_item};
      end
      restart_message();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_word(input sha1_pkg::rsp_payload_type got);
      sha1_pkg::rsp_payload_type want;
      if (expected_digest.size() == 0) begin
         report_mismatch("digest word with none outstanding", got.digest_word, '0);
         return;
      end
      want = expected_digest.pop_front();
      if (got.digest_word != want.digest_word) begin
         report_mismatch("digest_word", got.digest_word, want.digest_word);
      end
      if (got.word_number != want.word_number) begin
         report_mismatch("word_number", 32'(got.word_number), 32'(want.word_number));
      end
      if (got.last_word != want.last_word) begin
         report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         block_words[i] = '0;
      end
      restart_message();
   end

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         expected_digest.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_word(rsp_payload);
         end
         if (req_valid && req_ready) begin
            absorb_item(req_payload);
         end
      end
      words_pending <= expected_digest.size();
   end

endmodule

### tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 90;
   localparam int SENDER_IDLE [4]  = '{0, 88, 0, 19};
   localparam int RECEIVER_STALL [4] = '{0, 0, 88, 19};
   // lengths around the point where padding spills into a second block
   localparam int BOUNDARY_LEN [4] = '{55, 56, 63, 64};

   logic clock = 1'b0;
   logic reset = 1'b1;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   int mismatch_count;
   int words_pending;

   sha1_chan_if #(.payload_type(sha1_pkg::req_payload_type)) req_ch ();
   sha1_chan_if #(.payload_type(sha1_pkg::rsp_payload_type)) rsp_ch ();

   sha1_message_digest dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sha1_digest_checker digest_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_payload    (req_ch.payload),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_payload    (rsp_ch.payload),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input logic [7:0] b, input logic present, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{message_byte: b, byte_present: present, end_of_message: last};
      do @(posedge clock); while (!req_ch.ready);
      if (present || last) begin
         items_sent++;
      end
   endtask

   // random content; a message closes on its last byte or with a bare end marker
   task automatic send_message(input int len, input bit bare_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) begin
            send_item(8'($urandom), 1'b0, 1'b0);
         end
         send_item(8'($urandom), 1'b1, !bare_end && (i == len - 1));
      end
      if (bare_end || len == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic wait_for_digests();
      @(posedge clock);
      while (words_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_start;
      int len;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, "abc", extreme bytes, bare end after data, idle items
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'hC3, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      req_ch.valid <= 1'b0;
      wait_for_digests();

      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = SENDER_IDLE[ph];
         receiver_stall_pct = RECEIVER_STALL[ph];
         // first phase: hold the receiver off so the block backs up into its input
         if (ph == 0) begin
            hold_requests++;
         end
         phase_start = items_sent;
         send_message(BOUNDARY_LEN[ph], bit'($urandom_range(1)));
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               len = $urandom_range(66, 52);
            end else begin
               len = $urandom_range(12);
            end
            send_message(len, bit'($urandom_range(1)));
         end
         req_ch.valid <= 1'b0;
         wait_for_digests();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
